// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the date_to_moon_phase RTL.
// Needs clk and arst_n in the scope of use; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define DTMP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define DTMP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DTMP_ASSERT(lbl, prop, msg)
`define DTMP_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/dtmp_pkg.sv =====
// Shared constants, types and calendar tables for date_to_moon_phase.
// No dependencies.
package dtmp_pkg;

	localparam int DIST_W = 29;
	localparam int REM_W  = 19;

	// lunation length in units of 1e-4 day
	localparam logic [REM_W-1:0] LUNATION = 19'd295306;
	// floor(2^32 / LUNATION)
	localparam logic [13:0] RECIP_LUN = 14'd14544;
	// ceil(2^27 / 100), exact quotient for any 20-bit dividend
	localparam logic [20:0] RECIP_100 = 21'd1342178;
	localparam int RECIP_100_SH = 27;
	localparam logic [13:0] TEN_K = 14'd10000;

	localparam logic [DIST_W-1:0] REF_RESET = 29'd737817;
	localparam logic [19:0] YEAR_MAX = 20'd999999;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_YEAR = 2'd1;
	localparam logic [1:0] ERR_DAY  = 2'd2;
	localparam logic [1:0] ERR_MLEN = 2'd3;

	typedef struct packed {
		logic [1:0]        err;
		logic              after;
		logic [DIST_W-1:0] distance;
	} side_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/dtmp_date.sv =====
// Date check and day-number stages (two pipeline stages).
// Depends on dtmp_pkg.
module dtmp_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_in,
	input  logic [3:0]  month,
	input  logic [5:0]  day,
	input  logic [19:0] year,
	output logic        valid_out,
	output logic [dtmp_pkg::DIST_W-1:0] dn,
	output logic [1:0]  err
);

	// stage 0: range checks, py / 100 by reciprocal
	logic [19:0] py;
	logic [40:0] prod;
	logic [1:0]  err_pre;

	assign py   = year - 20'd1;
	assign prod = 41'(py) * 41'(dtmp_pkg::RECIP_100);

	always_comb begin
		if (year == 20'd0 || year > dtmp_pkg::YEAR_MAX) begin
			err_pre = dtmp_pkg::ERR_YEAR;
		end else if (day > 6'd31) begin
			err_pre = dtmp_pkg::ERR_DAY;
		end else if (month == 4'd0 || month > 4'd12) begin
			err_pre = dtmp_pkg::ERR_MLEN;
		end else begin
			err_pre = dtmp_pkg::ERR_NONE;
		end
	end

	logic        valid_s1;
	logic [19:0] py_s1;
	logic [40:0] prod_s1;
	logic [3:0]  month_s1;
	logic [5:0]  day_s1;
	logic [1:0]  err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			py_s1    <= py;
			prod_s1  <= prod;
			month_s1 <= month;
			day_s1   <= day;
			err_s1   <= err_pre;
		end
	end

	// stage 1: leap test, month length, day number
	logic [13:0] q100;
	logic [19:0] r_full;
	logic [6:0]  r100;
	logic        leap;
	logic        too_long;
	logic [1:0]  err_fin;
	logic [dtmp_pkg::DIST_W-1:0] dn_next;
	logic [5:0]  day_off;

	assign q100   = prod_s1[dtmp_pkg::RECIP_100_SH +: 14];
	assign r_full = py_s1 - 20'(21'(q100) * 21'd100);
	assign r100   = r_full[6:0];
	// year % 100 == 0 <=> py % 100 == 99; year % 400 == 0 adds (py / 100) % 4 == 3
	assign leap   = (py_s1[1:0] == 2'd3 && r100 != 7'd99) ||
	                (r100 == 7'd99 && q100[1:0] == 2'd3);

	assign too_long = (5'(day_s1) > dtmp_pkg::month_len(month_s1)) &&
	                  !(leap && month_s1 == 4'd2 && day_s1 == 6'd29);
	assign err_fin  = (err_s1 == dtmp_pkg::ERR_NONE && too_long) ? dtmp_pkg::ERR_MLEN : err_s1;

	// day zero counts like day one
	assign day_off = (day_s1 != 6'd0) ? day_s1 - 6'd1 : 6'd0;

	assign dn_next = 29'(py_s1) * 29'd365
	               + 29'(py_s1[19:2])
	               - 29'(q100)
	               + 29'(q100[13:2])
	               + 29'(dtmp_pkg::month_start(month_s1))
	               + 29'(leap && month_s1 > 4'd2)
	               + 29'(day_off);

	logic        valid_s2;
	logic [dtmp_pkg::DIST_W-1:0] dn_s2;
	logic [1:0]  err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s2  <= dn_next;
			err_s2 <= err_fin;
		end
	end

	assign valid_out = valid_s2;
	assign dn        = dn_s2;
	assign err       = err_s2;

endmodule

// ===== hw/rtl/dtmp_mod.sv =====
// Three-stage remainder modulo the lunation constant for a 32-bit value.
// Depends on dtmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtmp_mod (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_in,
	input  logic [31:0]           value,
	input  dtmp_pkg::side_t       side_in,
	output logic                  valid_out,
	output logic [dtmp_pkg::REM_W-1:0] rem,
	output dtmp_pkg::side_t       side_out
);

	// m1: quotient estimate from the upper half, never above the true quotient
	logic [29:0] p0;
	assign p0 = 30'(value[31:16]) * 30'(dtmp_pkg::RECIP_LUN);

	logic            valid_m1, valid_m2, valid_m3;
	logic [29:0]     p_m1;
	logic [31:0]     v_m1, v_m2;
	logic [31:0]     qd_m2;
	logic [dtmp_pkg::REM_W-1:0] rem_m3;
	dtmp_pkg::side_t side_m1, side_m2, side_m3;

	// m2: estimate times divisor; fits 32 bits since it does not exceed value
	logic [13:0] q_est;
	logic [32:0] qd;
	assign q_est = p_m1[29:16];
	assign qd    = 33'(q_est) * 33'(dtmp_pkg::LUNATION);

	// m3: estimate is short by at most one, one correction
	logic [31:0] t;
	logic [19:0] t20, r20;
	assign t   = v_m2 - qd_m2;
	assign t20 = t[19:0];
	assign r20 = (t20 >= 20'(dtmp_pkg::LUNATION)) ? t20 - 20'(dtmp_pkg::LUNATION) : t20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_m1 <= 1'b0;
			valid_m2 <= 1'b0;
			valid_m3 <= 1'b0;
		end else if (en) begin
			valid_m1 <= valid_in;
			valid_m2 <= valid_m1;
			valid_m3 <= valid_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_m1    <= p0;
			v_m1    <= value;
			side_m1 <= side_in;
			qd_m2   <= qd[31:0];
			v_m2    <= v_m1;
			side_m2 <= side_m1;
			rem_m3  <= r20[dtmp_pkg::REM_W-1:0];
			side_m3 <= side_m2;
		end
	end

	assign valid_out = valid_m3;
	assign rem       = rem_m3;
	assign side_out  = side_m3;

	`DTMP_ASSERT(a_rem_reduced, valid_out |-> rem < dtmp_pkg::LUNATION, "remainder not reduced")

endmodule

// ===== hw/rtl/date_to_moon_phase.sv =====
// date_to_moon_phase: calendar date to day distance and moon phase.
// Pipeline: 12 register stages from the input transfer to result_valid.
// Throughput: one date per cycle; the whole pipe holds only while a result is stalled.
// Reset clears every stage valid bit and loads the reference with day 737817.
// Error results carry zero distance, after flag and phase.
`include "assert_macros.svh"

module date_to_moon_phase (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic [28:0] cfg_wdata,
	// date channel
	input  logic        date_valid,
	output logic        date_stall,
	input  logic [3:0]  month,
	input  logic [5:0]  day,
	input  logic [19:0] year,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  phase,
	output logic [1:0]  error_code,
	output logic [28:0] day_distance,
	output logic        after_reference
);

	localparam logic [2:0] PH_FULL      = 3'd0;
	localparam logic [2:0] PH_WAN_GIBB  = 3'd1;
	localparam logic [2:0] PH_THIRD_Q   = 3'd2;
	localparam logic [2:0] PH_WAN_CRES  = 3'd3;
	localparam logic [2:0] PH_NEW       = 3'd4;
	localparam logic [2:0] PH_WAX_CRES  = 3'd5;
	localparam logic [2:0] PH_FIRST_Q   = 3'd6;
	localparam logic [2:0] PH_WAX_GIBB  = 3'd7;

	// band edges k/100 scaled: compare f*100 against k*LUNATION
	localparam logic [24:0] TH_03 = 25'(3  * dtmp_pkg::LUNATION);
	localparam logic [24:0] TH_22 = 25'(22 * dtmp_pkg::LUNATION);
	localparam logic [24:0] TH_28 = 25'(28 * dtmp_pkg::LUNATION);
	localparam logic [24:0] TH_47 = 25'(47 * dtmp_pkg::LUNATION);
	localparam logic [24:0] TH_53 = 25'(53 * dtmp_pkg::LUNATION);
	localparam logic [24:0] TH_72 = 25'(72 * dtmp_pkg::LUNATION);
	localparam logic [24:0] TH_78 = 25'(78 * dtmp_pkg::LUNATION);
	localparam logic [24:0] TH_97 = 25'(97 * dtmp_pkg::LUNATION);

	// Global advance: every stage moves unless the output holds a stalled result.
	// Bubbles anywhere still move forward while the output is free.
	logic en;
	logic valid_s6;
	assign en         = !(valid_s6 && result_stall);
	assign date_stall = !en;

	// Reference register; write it only while the pipe is empty (the block itself does not enforce this).
	logic [28:0] ref_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= dtmp_pkg::REF_RESET;
		end else if (cfg_wen) begin
			ref_q <= cfg_wdata;
		end
	end

	// s1..s2: date check and day number
	logic        valid_dn;
	logic [28:0] dn;
	logic [1:0]  err_dn;

	dtmp_date u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (date_valid),
		.month     (month),
		.day       (day),
		.year      (year),
		.valid_out (valid_dn),
		.dn        (dn),
		.err       (err_dn)
	);

	// s3: distance to reference; errors force distance and direction to zero,
	// which also drives the phase to full further down
	logic            after_c;
	logic [28:0]     dist_c;
	logic            valid_s3;
	dtmp_pkg::side_t side_s3;

	assign after_c = (err_dn == dtmp_pkg::ERR_NONE) && (dn > ref_q);
	always_comb begin
		if (err_dn != dtmp_pkg::ERR_NONE) begin
			dist_c = '0;
		end else if (dn > ref_q) begin
			dist_c = dn - ref_q;
		end else begin
			dist_c = ref_q - dn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_dn;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.err      <= err_dn;
			side_s3.after    <= after_c;
			side_s3.distance <= dist_c;
		end
	end

	// first reduction: dist mod L (keeps the 1e4 scaling in 32 bits)
	logic            valid_a;
	logic [18:0]     rem_a;
	dtmp_pkg::side_t side_a;

	dtmp_mod u_mod_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s3),
		.value     (32'(side_s3.distance)),
		.side_in   (side_s3),
		.valid_out (valid_a),
		.rem       (rem_a),
		.side_out  (side_a)
	);

	// s4: scale by 1e4; below 2^32 since rem_a < L
	logic [32:0]     scaled;
	logic            valid_s4;
	logic [31:0]     y_s4;
	dtmp_pkg::side_t side_s4;

	assign scaled = 33'(rem_a) * 33'(dtmp_pkg::TEN_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s4    <= scaled[31:0];
			side_s4 <= side_a;
		end
	end

	// second reduction: lunation fraction numerator r
	logic            valid_b;
	logic [18:0]     rem_b;
	dtmp_pkg::side_t side_b;

	dtmp_mod u_mod_frac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s4),
		.value     (y_s4),
		.side_in   (side_s4),
		.valid_out (valid_b),
		.rem       (rem_b),
		.side_out  (side_b)
	);

	// s5: on or before the reference the fraction runs backward
	logic            valid_s5;
	logic [18:0]     f_s5;
	dtmp_pkg::side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s5    <= side_b.after ? rem_b : dtmp_pkg::LUNATION - rem_b;
			side_s5 <= side_b;
		end
	end

	// s6: phase bands, exact compare; this stage is the output register
	logic [24:0] fx;
	logic [2:0]  phase_c;

	assign fx = 25'(f_s5) * 25'd100;

	always_comb begin
		if (fx <= TH_03 || fx >= TH_97) begin
			phase_c = PH_FULL;
		end else if (fx < TH_22) begin
			phase_c = PH_WAN_GIBB;
		end else if (fx <= TH_28) begin
			phase_c = PH_THIRD_Q;
		end else if (fx < TH_47) begin
			phase_c = PH_WAN_CRES;
		end else if (fx <= TH_53) begin
			phase_c = PH_NEW;
		end else if (fx < TH_72) begin
			phase_c = PH_WAX_CRES;
		end else if (fx <= TH_78) begin
			phase_c = PH_FIRST_Q;
		end else begin
			phase_c = PH_WAX_GIBB;
		end
	end

	logic [2:0]  phase_s6;
	logic [1:0]  err_s6;
	logic [28:0] dist_s6;
	logic        after_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s6 <= phase_c;
			err_s6   <= side_s5.err;
			dist_s6  <= side_s5.distance;
			after_s6 <= side_s5.after;
		end
	end

	assign result_valid    = valid_s6;
	assign phase           = phase_s6;
	assign error_code      = err_s6;
	assign day_distance    = dist_s6;
	assign after_reference = after_s6;

	`DTMP_ASSERT(a_err_zero, result_valid && error_code != dtmp_pkg::ERR_NONE |-> day_distance == '0 && !after_reference && phase == PH_FULL, "error result not cleared")
	`DTMP_NEVER(a_after_dist, result_valid && after_reference && day_distance == '0, "after flag with zero distance")

endmodule

// ===== sim/date_to_moon_phase_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for date_to_moon_phase: random and directed dates, bursty sender,
// patterned result stall, per-field compare against an in-bench phase predictor.
// Depends on dtmp_pkg and the date_to_moon_phase RTL.
module date_to_moon_phase_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;		// a little over the 12-stage pipe
	localparam logic [dtmp_pkg::DIST_W-1:0] REF_TOP = 29'd365999634;
	localparam int unsigned MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned MONTH_OFFSET [1:12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	typedef enum logic [2:0] {
		PH_FULL, PH_WANING_GIBBOUS, PH_THIRD_QUARTER, PH_WANING_CRESCENT,
		PH_NEW, PH_WAXING_CRESCENT, PH_FIRST_QUARTER, PH_WAXING_GIBBOUS
	} moon_phase_e;

	typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

	typedef struct {
		logic [3:0]  month;
		logic [5:0]  day;
		logic [19:0] year;
	} date_item_t;

	typedef struct {
		moon_phase_e                 phase;
		logic [1:0]                  err;
		logic [dtmp_pkg::DIST_W-1:0] distance;
		logic                        after;
	} moon_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic [28:0]       cfg_wdata = '0;
	logic              date_valid = 1'b0;
	logic              date_stall;
	logic [3:0]        month = 4'd1;
	logic [5:0]        day = 6'd1;
	logic [19:0]       year = 20'd1;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [2:0]        phase;
	logic [1:0]        error_code;
	logic [28:0]       day_distance;
	logic              after_reference;

	date_item_t        queued_dates [$];
	moon_result_t      awaited_moon_results [$];
	// bench copy of the reference register
	logic [dtmp_pkg::DIST_W-1:0] reference_dn = dtmp_pkg::REF_RESET;
	int                fault_count = 0;
	int                cycle_count = 0;
	logic              date_taken = 1'b0;
	int                burst_left = 1;
	int                idle_left = 0;
	stall_mode_e       stall_mode = STALL_NONE;
	int                stall_hold = 0;

	date_to_moon_phase DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.date_valid(date_valid),
		.date_stall(date_stall),
		.month(month),
		.day(day),
		.year(year),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.phase(phase),
		.error_code(error_code),
		.day_distance(day_distance),
		.after_reference(after_reference)
	);

	always #10 clk = ~clk;

	function automatic bit is_gregorian_leap(input logic [19:0] y);
		return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
	endfunction

	// month must be 1..12 here
	function automatic int unsigned days_in_month(input logic [3:0] m, input bit lp);
		return (m == 4'd2 && lp) ? 29 : MONTH_DAYS[m];
	endfunction

	// Expected result for one date against the given reference day number.
	function automatic moon_result_t compute_moon_result(input logic [3:0] m, input logic [5:0] d,
			input logic [19:0] y, input logic [dtmp_pkg::DIST_W-1:0] ref_dn);
		moon_result_t res;
		bit lp;
		int unsigned py, dn, distance;
		logic [63:0] rem, frac, x, lun;
		res.phase = PH_FULL;
		res.err = dtmp_pkg::ERR_NONE;
		res.distance = '0;
		res.after = 1'b0;
		lp = is_gregorian_leap(y);
		// year first, then day above 31, then month length
		if (y == 0 || y > dtmp_pkg::YEAR_MAX)
			res.err = dtmp_pkg::ERR_YEAR;
		else if (d > 31)
			res.err = dtmp_pkg::ERR_DAY;
		else if (m < 1 || m > 12)
			res.err = dtmp_pkg::ERR_MLEN;
		else if (d > days_in_month(m, lp))
			res.err = dtmp_pkg::ERR_MLEN;
		if (res.err == dtmp_pkg::ERR_NONE) begin
			py = y - 1;
			dn = py * 365 + py / 4 - py / 100 + py / 400 + MONTH_OFFSET[m];
			if (lp && m > 2)
				dn = dn + 1;
			if (d != 0)		// day zero counts as day one
				dn = dn + d - 1;
			res.after = dn > ref_dn;
			distance = res.after ? dn - ref_dn : ref_dn - dn;
			res.distance = distance[dtmp_pkg::DIST_W-1:0];
			// exact fraction rem/LUNATION; mirrored when on or before the reference
			lun = 64'(dtmp_pkg::LUNATION);
			rem = (64'(distance) * 64'd10000) % lun;
			frac = res.after ? rem : lun - rem;
			x = frac * 64'd100;
			if (x <= 3 * lun || x >= 97 * lun)
				res.phase = PH_FULL;
			else if (x < 22 * lun)
				res.phase = PH_WANING_GIBBOUS;
			else if (x <= 28 * lun)
				res.phase = PH_THIRD_QUARTER;
			else if (x < 47 * lun)
				res.phase = PH_WANING_CRESCENT;
			else if (x <= 53 * lun)
				res.phase = PH_NEW;
			else if (x < 72 * lun)
				res.phase = PH_WAXING_CRESCENT;
			else if (x <= 78 * lun)
				res.phase = PH_FIRST_QUARTER;
			else
				res.phase = PH_WAXING_GIBBOUS;
		end
		return res;
	endfunction

	// Mostly legal dates spread over eras that stress the leap rule; the rest is broken input.
	function automatic date_item_t random_date();
		date_item_t it;
		int unsigned len;
		it.month = 4'($urandom_range(1, 12));
		case ($urandom_range(0, 5))
			0: it.year = 20'($urandom_range(1, 999999));
			1: it.year = 20'($urandom_range(1900, 2100));
			2: it.year = 20'($urandom_range(1, 2499) * 400);
			3: it.year = 20'($urandom_range(1, 9999) * 100);
			4: it.year = 20'($urandom_range(1, 50));
			default: it.year = 20'($urandom_range(999950, 999999));
		endcase
		len = days_in_month(it.month, is_gregorian_leap(it.year));
		it.day = 6'($urandom_range(0, len));
		if ($urandom_range(0, 9) < 2) begin
			case ($urandom_range(0, 2))
				0: begin
					it.month = 4'($urandom);
					it.day = 6'($urandom);
					it.year = 20'($urandom);
				end
				1: it.day = 6'($urandom_range(len + 1, ($urandom_range(0, 3) == 0) ? 63 : 31));
				default: it.year = ($urandom_range(0, 1) == 0) ? 20'd0 :
					20'($urandom_range(1000000, 1048575));
			endcase
		end
		return it;
	endfunction

	task automatic add_date(input logic [3:0] m, input logic [5:0] d, input logic [19:0] y);
		date_item_t it;
		it.month = m;
		it.day = d;
		it.year = y;
		queued_dates = {queued_dates, it};
	endtask

	task automatic add_random_dates(input int count);
		repeat (count) queued_dates = {queued_dates, random_date()};
	endtask

	// hold the sender off until the pipe is empty and every result is back
	task automatic drain_pipe();
		while (queued_dates.size() != 0 || date_valid || awaited_moon_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_reference(input logic [dtmp_pkg::DIST_W-1:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		reference_dn = value;
	endtask

	// Date driver: pops the pending queue in bursts, idles between them. Changes on the
	// falling edge only, and holds the payload until the transfer is seen.
	always @(negedge clk) begin
		date_item_t nxt;
		if (arst_n && (!date_valid || date_taken)) begin
			if (idle_left != 0) begin
				date_valid <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (queued_dates.size() != 0) begin
				nxt = queued_dates.pop_front();
				month <= nxt.month;
				day <= nxt.day;
				year <= nxt.year;
				date_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					// a third of the bursts run back to back
					idle_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				date_valid <= 1'b0;
			end
		end
	end

	// Result stall: pick a pattern, keep it for a while, then pick again.
	always @(negedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			stall_hold <= $urandom_range(20, 80);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_mode)
			STALL_NONE:     result_stall <= 1'b0;
			STALL_COIN:     result_stall <= 1'($urandom_range(0, 1));
			STALL_PERIODIC: result_stall <= (cycle_count % 5) < 2;
			default:        result_stall <= $urandom_range(0, 7) != 0;
		endcase
	end

	// Monitor: record date transfers as expectations, check each result transfer.
	always @(posedge clk) begin
		moon_result_t want;
		date_taken <= date_valid && !date_stall;
		if (date_valid && !date_stall)
			awaited_moon_results = {awaited_moon_results,
				compute_moon_result(month, day, year, reference_dn)};
		if (result_valid === 1'b1 && result_stall == 1'b0) begin
			if (awaited_moon_results.size() == 0) begin
				fault_count <= fault_count + 1;
				if (fault_count < 10)
					$display("unexpected result: phase %0d err %0d dist %0d after %0d",
						phase, error_code, day_distance, after_reference);
			end else begin
				want = awaited_moon_results.pop_front();
				if (phase !== want.phase || error_code !== want.err ||
						day_distance !== want.distance || after_reference !== want.after) begin
					fault_count <= fault_count + 1;
					if (fault_count < 10)
						$display("mismatch: exp phase %0d err %0d dist %0d after %0d, %s",
							want.phase, want.err, want.distance, want.after,
							$sformatf("got phase %0d err %0d dist %0d after %0d",
								phase, error_code, day_distance, after_reference));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed dates against the reset reference (Jan 28 2021).
		add_date(4'd1, 6'd28, 20'd2021);		// equal to reference: full, distance 0
		add_date(4'd1, 6'd29, 20'd2021);
		add_date(4'd1, 6'd27, 20'd2021);
		add_date(4'd2, 6'd1, 20'd2021);			// walk through the lunation after the reference
		add_date(4'd2, 6'd4, 20'd2021);
		add_date(4'd2, 6'd8, 20'd2021);
		add_date(4'd2, 6'd12, 20'd2021);
		add_date(4'd2, 6'd15, 20'd2021);
		add_date(4'd2, 6'd19, 20'd2021);
		add_date(4'd2, 6'd23, 20'd2021);
		add_date(4'd1, 6'd20, 20'd2021);		// before the reference, mirrored fraction
		add_date(4'd2, 6'd29, 20'd2020);		// leap day, divisible by 4
		add_date(4'd2, 6'd29, 20'd2021);		// not a leap year
		add_date(4'd2, 6'd29, 20'd1900);		// century, not leap
		add_date(4'd2, 6'd29, 20'd2000);		// 400-year, leap
		add_date(4'd3, 6'd0, 20'd2021);			// day zero counts as day one
		add_date(4'd4, 6'd31, 20'd2021);		// beyond month length
		add_date(4'd4, 6'd32, 20'd2021);		// day above 31
		add_date(4'd0, 6'd63, 20'd5);			// day check wins over bad month
		add_date(4'd0, 6'd5, 20'd5);			// month zero
		add_date(4'd13, 6'd1, 20'd5);
		add_date(4'd15, 6'd31, 20'd5);
		add_date(4'd1, 6'd10, 20'd0);			// year zero
		add_date(4'd15, 6'd63, 20'hFFFFF);		// year check wins over everything
		add_date(4'd12, 6'd31, 20'd999999);
		drain_pipe();

		// Reference at the low extreme: the first day is equal, everything else after.
		write_reference('0);
		add_date(4'd1, 6'd1, 20'd1);
		add_random_dates(60);
		drain_pipe();

		// Reference at the high extreme: every legal date lies before it.
		write_reference(REF_TOP);
		add_random_dates(60);
		drain_pipe();

		repeat (3) begin
			write_reference(29'($urandom_range(0, REF_TOP)));
			add_random_dates(35);
			drain_pipe();		// sender waits out every pending result mid-run
			add_random_dates(35);
			drain_pipe();
		end

		// Back to the reset value by a write.
		write_reference(dtmp_pkg::REF_RESET);
		add_random_dates(100);
		drain_pipe();

		if (fault_count == 0 && awaited_moon_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
